// ===== src/sdts_pkg.sv =====
// Types and constants shared by the stepper dial-timer sequencer.
package sdts_pkg;

	localparam int START_W = 12;
	localparam int WIG_W   = 11;
	localparam int SLOW_W  = 8;
	localparam int PCT_W   = 7;
	localparam int OP_W    = 2;
	localparam int CIDX_W  = 2;

	localparam logic [START_W-1:0] START_MAX = '1;
	localparam logic [WIG_W-1:0]  WIGGLE_SPAN_RST  = 11'd500;
	localparam logic [SLOW_W-1:0] SLOW_DIVIDER_RST = 8'd8;

	// percent saturates here so the target stays below a full turn
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd99;
	localparam int PctDiv  = 100;
	localparam int PCT_TAB = 100;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_SET   = 2'd1,
		MODE_COUNT = 2'd2,
		MODE_RING  = 2'd3
	} mode_t;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
	localparam logic [OP_W-1:0] OP_ACK    = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_WIGGLE_SPAN  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SLOW_DIVIDER = 2'd1;

endpackage

// ===== src/stepper_dial_timer_sequencer.sv =====
// Stepper dial-timer sequencer: mode control, step generation and position tracking.
//
// Usage:
//   Requests enter on in_valid/in_ready with operation (tick, set target percent,
//   ring acknowledge) and percent. Each request yields exactly one result on
//   out_valid/out_ready: step level, direction, fine-step select, dial position,
//   mode and motor-running flag, all showing the state after that request.
//   Configuration (wiggle_span at index 0, slow_divider at index 1) is written on
//   cfg_valid/cfg_ready, which is always high; the user must write it only while no
//   request is in flight; the block does not enforce it.
// Pipeline and throughput:
//   An accepted request is held in the input stage; its update is then applied and
//   the result registered in the state/result registers, a single pass of compares
//   and increments. One request per cycle is sustained while out_ready is high.
// Reset:
//   arst_n clears both stages, puts the dial in start mode with the motor
//   running at position zero, and loads wiggle_span 500 and slow_divider 8.
// Stall:
//   While out_valid is high and out_ready low, result and state hold; the input
//   stage still takes one request, then in_ready drops until the result is taken.
module stepper_dial_timer_sequencer #(
	parameter int POSITIONS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sdts_pkg::OP_W-1:0]      operation,
	input  logic [sdts_pkg::PCT_W-1:0]     percent,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           step_level,
	output logic                           turn_back,
	output logic                           fine_step,
	output logic [$clog2(POSITIONS)-1:0]   dial_position,
	output logic [1:0]                     mode,
	output logic                           motor_running,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sdts_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [sdts_pkg::WIG_W-1:0]     cfg_data
);

	localparam int POS_W = $clog2(POSITIONS);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(POSITIONS - 1);

	// target table: floor(POSITIONS * pct / 100), worked out at elaboration
	logic [POS_W-1:0] tgt_tab [sdts_pkg::PCT_TAB];
	for (genvar i = 0; i < sdts_pkg::PCT_TAB; i++) begin : g_tab
		assign tgt_tab[i] = POS_W'((POSITIONS * i) / sdts_pkg::PctDiv);
	end

	// configuration
	logic [sdts_pkg::WIG_W-1:0]  wiggle_span_q;
	logic [sdts_pkg::SLOW_W-1:0] slow_divider_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiggle_span_q  <= sdts_pkg::WIGGLE_SPAN_RST;
			slow_divider_q <= sdts_pkg::SLOW_DIVIDER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sdts_pkg::CFG_WIGGLE_SPAN:  wiggle_span_q  <= cfg_data;
				sdts_pkg::CFG_SLOW_DIVIDER: slow_divider_q <= cfg_data[sdts_pkg::SLOW_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic                       valid_s1;
	logic [sdts_pkg::OP_W-1:0]  op_s1;
	logic [sdts_pkg::PCT_W-1:0] pct_s1;
	logic                       advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= operation;
			pct_s1 <= percent;
		end
	end

	// dial state; these registers are also the result
	sdts_pkg::mode_t              mode_q;
	logic                         run_q;
	logic                         step_q;
	logic                         dir_q;
	logic [POS_W-1:0]             pos_q;
	logic [POS_W-1:0]             target_q;
	logic [sdts_pkg::START_W-1:0] start_cnt_q;
	logic [sdts_pkg::WIG_W-1:0]   wig_cnt_q;
	logic [sdts_pkg::SLOW_W-1:0]  slow_cnt_q;

	sdts_pkg::mode_t              mode_nx;
	logic                         run_nx;
	logic                         step_nx;
	logic                         dir_nx;
	logic [POS_W-1:0]             pos_nx;
	logic [POS_W-1:0]             target_nx;
	logic [sdts_pkg::START_W-1:0] start_cnt_nx;
	logic [sdts_pkg::WIG_W-1:0]   wig_cnt_nx;
	logic [sdts_pkg::SLOW_W-1:0]  slow_cnt_nx;
	logic                         do_move;
	logic [sdts_pkg::PCT_W-1:0]   pct_sat;

	assign pct_sat = (pct_s1 > sdts_pkg::PCT_MAX) ? sdts_pkg::PCT_MAX : pct_s1;

	always_comb begin
		mode_nx      = mode_q;
		run_nx       = run_q;
		step_nx      = step_q;
		dir_nx       = dir_q;
		pos_nx       = pos_q;
		target_nx    = target_q;
		start_cnt_nx = start_cnt_q;
		wig_cnt_nx   = wig_cnt_q;
		slow_cnt_nx  = slow_cnt_q;
		do_move      = 1'b0;

		unique case (op_s1)
			sdts_pkg::OP_TICK: begin
				if (run_q) begin
					step_nx = ~step_q;
					do_move = 1'b1;
					unique case (mode_q)
						sdts_pkg::MODE_START: begin
							if (start_cnt_q != sdts_pkg::START_MAX)
								start_cnt_nx = start_cnt_q + 1'b1;
							if (start_cnt_nx < {wiggle_span_q, 1'b0}) begin
								dir_nx = (start_cnt_nx > {1'b0, wiggle_span_q});
							end else begin
								// wiggle done: stop and wait for a target
								run_nx  = 1'b0;
								mode_nx = sdts_pkg::MODE_SET;
							end
						end
						sdts_pkg::MODE_SET: begin
							dir_nx = !(pos_q < target_q);
							if (pos_q == target_q)
								mode_nx = sdts_pkg::MODE_COUNT;
						end
						sdts_pkg::MODE_COUNT: begin
							dir_nx = 1'b1;
							if (pos_q == '0) begin
								dir_nx     = 1'b0;
								wig_cnt_nx = '0;
								mode_nx    = sdts_pkg::MODE_RING;
							end
							// move only once every slow_divider ticks
							slow_cnt_nx = slow_cnt_q + 1'b1;
							if (slow_cnt_nx >= slow_divider_q)
								slow_cnt_nx = '0;
							else
								do_move = 1'b0;
						end
						sdts_pkg::MODE_RING: begin
							wig_cnt_nx = wig_cnt_q + 1'b1;
							if (wig_cnt_nx >= wiggle_span_q) begin
								wig_cnt_nx = '0;
								dir_nx     = ~dir_q;
							end
						end
						default: ;
					endcase
				end
			end
			sdts_pkg::OP_TARGET: begin
				if (mode_q == sdts_pkg::MODE_SET) begin
					target_nx = tgt_tab[pct_sat];
					run_nx    = 1'b1;
				end
			end
			sdts_pkg::OP_ACK: begin
				if (mode_q == sdts_pkg::MODE_RING) begin
					mode_nx = sdts_pkg::MODE_SET;
					run_nx  = 1'b0;
				end
			end
			default: ;
		endcase

		if (do_move) begin
			if (!dir_nx)
				pos_nx = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
			else
				pos_nx = (pos_q == '0) ? POS_LAST : pos_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			mode_q      <= sdts_pkg::MODE_START;
			run_q       <= 1'b1;
			step_q      <= 1'b0;
			dir_q       <= 1'b0;
			pos_q       <= '0;
			target_q    <= '0;
			start_cnt_q <= '0;
			wig_cnt_q   <= '0;
			slow_cnt_q  <= '0;
		end else begin
			if (advance || out_ready)
				out_valid <= advance;
			if (advance) begin
				mode_q      <= mode_nx;
				run_q       <= run_nx;
				step_q      <= step_nx;
				dir_q       <= dir_nx;
				pos_q       <= pos_nx;
				target_q    <= target_nx;
				start_cnt_q <= start_cnt_nx;
				wig_cnt_q   <= wig_cnt_nx;
				slow_cnt_q  <= slow_cnt_nx;
			end
		end
	end

	assign step_level    = step_q;
	assign turn_back     = dir_q;
	assign fine_step     = (mode_q == sdts_pkg::MODE_COUNT);
	assign dial_position = pos_q;
	assign mode          = mode_q;
	assign motor_running = run_q;

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < POSITIONS)
		else $error("dial position out of range");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == sdts_pkg::MODE_START) |-> run_q)
		else $error("motor stopped in start mode");

	a_tick_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == sdts_pkg::OP_TICK && run_q) |=> (step_q != $past(step_q)))
		else $error("running tick did not toggle step pin");

	a_ack_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == sdts_pkg::OP_ACK && mode_q == sdts_pkg::MODE_RING)
		|=> (mode_q == sdts_pkg::MODE_SET && !run_q))
		else $error("ring acknowledge did not stop the motor");
`endif

endmodule
